// ===== hw/rtl/key_matrix_midi_note_events_unit_macros.svh =====
// ---------------------------------------------------------------------------
// key matrix midi note events unit: assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef KEY_MATRIX_MIDI_NOTE_EVENTS_UNIT_MACROS_SVH
`define KEY_MATRIX_MIDI_NOTE_EVENTS_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define KMNE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define KMNE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kmne_pkg.sv =====
// ---------------------------------------------------------------------------
// kmne_pkg
// types and constants shared by the key matrix midi note event block
// ---------------------------------------------------------------------------
package kmne_pkg;

  localparam int COL_W  = 4;
  localparam int ROW_W  = 3;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int CHAN_W = 4;
  localparam int STAT_W = 8;
  localparam int CFG_W  = 7;

  localparam logic [STAT_W-1:0] NOTE_ON_CODE  = 8'h90;
  localparam logic [STAT_W-1:0] NOTE_OFF_CODE = 8'h80;

  localparam logic [VEL_W-1:0] VELOCITY_RESET = 7'd100;

  // request kinds carried in tuser
  localparam logic REQ_MAP_WRITE = 1'b0;
  localparam logic REQ_SCAN      = 1'b1;

  // configuration register indexes
  localparam logic CFG_MIDI_CHANNEL  = 1'b0;
  localparam logic CFG_NOTE_VELOCITY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_SEND
  } kmne_state_t;

  typedef struct packed {
    logic map_write;
    logic load_scan;
    logic pick;
  } kmne_cmd_t;

  typedef struct packed {
    logic scan_change;
    logic msg_last;
  } kmne_status_t;

endpackage

// ===== hw/rtl/kmne_ctrl.sv =====
// ---------------------------------------------------------------------------
// kmne_ctrl
// sequencer: takes one item, then walks the changed keys one message each
// ---------------------------------------------------------------------------
module kmne_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tuser,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output kmne_pkg::kmne_cmd_t    cmd,
  input  kmne_pkg::kmne_status_t status
);
  import kmne_pkg::*;

  kmne_state_t state;
  kmne_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tuser == REQ_SCAN && status.scan_change) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (m_tready) begin
          state_next = status.msg_last ? ST_IDLE : ST_PICK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    cmd.map_write = 1'b0;
    cmd.load_scan = 1'b0;
    cmd.pick      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.map_write = s_tvalid && s_tuser == REQ_MAP_WRITE;
        cmd.load_scan = s_tvalid && s_tuser == REQ_SCAN;
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
      end
      ST_SEND: begin
        m_tvalid = 1'b1;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/kmne_datapath.sv =====
// ---------------------------------------------------------------------------
// kmne_datapath
// key state, note map memory, pending change masks and message register
// ---------------------------------------------------------------------------
module kmne_datapath #(
  parameter int ROW_COUNT    = 8,
  parameter int COLUMN_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [kmne_pkg::CFG_W-1:0]    cfg_data,
  input  logic [kmne_pkg::COL_W-1:0]    scan_column,
  input  logic [7:0]                    row_levels,
  input  logic [kmne_pkg::COL_W-1:0]    map_column,
  input  logic [kmne_pkg::ROW_W-1:0]    map_row,
  input  logic [kmne_pkg::NOTE_W-1:0]   map_note,
  input  kmne_pkg::kmne_cmd_t           cmd,
  output kmne_pkg::kmne_status_t        status,
  output logic [kmne_pkg::STAT_W-1:0]   midi_status,
  output logic [kmne_pkg::NOTE_W-1:0]   midi_note,
  output logic [kmne_pkg::VEL_W-1:0]    midi_velocity,
  output logic [kmne_pkg::ROW_W-1:0]    event_row,
  output logic [kmne_pkg::COL_W-1:0]    event_column,
  output logic                          last
);
  import kmne_pkg::*;

  localparam int CIDX_W    = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam int MAP_AW    = CIDX_W + ROW_W;
  localparam int MAP_DEPTH = 2 ** MAP_AW;

  logic [CHAN_W-1:0]    midi_channel;
  logic [VEL_W-1:0]     note_velocity;
  logic [ROW_COUNT-1:0] key_down [COLUMN_COUNT];
  logic [NOTE_W-1:0]    note_map [MAP_DEPTH];
  logic [ROW_COUNT-1:0] on_mask;
  logic [ROW_COUNT-1:0] off_mask;
  logic [COL_W-1:0]     cur_col;
  logic [ROW_W-1:0]     msg_row;
  logic                 msg_on;
  logic                 msg_last;
  logic [NOTE_W-1:0]    note_q;

  logic                 col_ok;
  logic                 map_ok;
  logic [CIDX_W-1:0]    scan_idx;
  logic [ROW_COUNT-1:0] levels;
  logic [ROW_COUNT-1:0] old_down;
  logic [ROW_COUNT-1:0] pressed;
  logic [ROW_COUNT-1:0] released;
  logic                 sel_on;
  logic [ROW_W-1:0]     sel_row;
  logic [ROW_COUNT-1:0] sel_bit;
  logic [ROW_COUNT-1:0] on_mask_next;
  logic [ROW_COUNT-1:0] off_mask_next;

  function automatic logic [ROW_W-1:0] lowest_row(input logic [ROW_COUNT-1:0] mask);
    logic [ROW_W-1:0] idx;
    idx = '0;
    for (int r = ROW_COUNT - 1; r >= 0; r--) begin
      if (mask[r]) begin
        idx = ROW_W'(r);
      end
    end
    return idx;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      midi_channel  <= '0;
      note_velocity <= VELOCITY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIDI_CHANNEL) begin
        midi_channel <= cfg_data[CHAN_W-1:0];
      end else begin
        note_velocity <= cfg_data[VEL_W-1:0];
      end
    end
  end

  // scan compare
  assign col_ok   = {1'b0, scan_column} < (COL_W + 1)'(COLUMN_COUNT);
  assign map_ok   = ({1'b0, map_column} < (COL_W + 1)'(COLUMN_COUNT)) &&
                    ({1'b0, map_row} < (ROW_W + 1)'(ROW_COUNT));
  assign scan_idx = scan_column[CIDX_W-1:0];
  assign levels   = row_levels[ROW_COUNT-1:0];
  assign old_down = key_down[scan_idx];
  assign pressed  = levels & ~old_down;
  assign released = ~levels & old_down;

  assign status.scan_change = col_ok && (|(pressed | released));
  assign status.msg_last    = msg_last;

  // next message: note-ons first, then note-offs, lowest row first
  always_comb begin
    sel_on        = |on_mask;
    sel_row       = sel_on ? lowest_row(on_mask) : lowest_row(off_mask);
    sel_bit       = ROW_COUNT'(1) << sel_row;
    on_mask_next  = sel_on ? (on_mask & ~sel_bit) : on_mask;
    off_mask_next = sel_on ? off_mask : (off_mask & ~sel_bit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COLUMN_COUNT; c++) begin
        key_down[c] <= '0;
      end
      on_mask  <= '0;
      off_mask <= '0;
      msg_on   <= 1'b0;
      msg_last <= 1'b0;
    end else begin
      if (cmd.load_scan && col_ok) begin
        key_down[scan_idx] <= levels;
        on_mask            <= pressed;
        off_mask           <= released;
      end
      if (cmd.pick) begin
        on_mask  <= on_mask_next;
        off_mask <= off_mask_next;
        msg_on   <= sel_on;
        msg_last <= ~(|(on_mask_next | off_mask_next));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_scan && col_ok) begin
      cur_col <= scan_column;
    end
    if (cmd.pick) begin
      msg_row <= sel_row;
    end
  end

  // note map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.map_write && map_ok) begin
      note_map[{map_column[CIDX_W-1:0], map_row}] <= map_note;
    end
    if (cmd.pick) begin
      note_q <= note_map[{cur_col[CIDX_W-1:0], sel_row}];
    end
  end

  assign midi_status   = (msg_on ? NOTE_ON_CODE : NOTE_OFF_CODE) |
                         {{(STAT_W - CHAN_W){1'b0}}, midi_channel};
  assign midi_note     = note_q;
  assign midi_velocity = note_velocity;
  assign event_row     = msg_row;
  assign event_column  = cur_col;
  assign last          = msg_last;

endmodule

// ===== hw/rtl/key_matrix_midi_note_events_unit.sv =====
// ---------------------------------------------------------------------------
// key_matrix_midi_note_events_unit
// turns key matrix column scans into midi note-on and note-off messages
// ---------------------------------------------------------------------------
// The slave stream carries either a note map write (tuser 0) or a column
// scan (tuser 1). A map write stores the note of one key and yields nothing.
// A scan compares the column's row levels with the stored pressed bits and
// sends one master-stream message per changed key: note-ons first, then
// note-offs, each in ascending row order, tlast on the final message.
// A scan with no change, or with a column beyond the matrix, yields nothing.
// An item is taken only while the block is idle. For a scan with changes,
// each message passes through a pick state (one note map read) and then a
// send state that offers it on the master stream until tready is high. The
// slave side is ready again in the cycle after the last message transfers.
// A stalled receiver holds the message in the output register; no new item
// is taken meanwhile. Reset clears all pressed bits, sets channel 0 and
// velocity 100; the note map holds no value until written.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and are meant for idle periods.
// ---------------------------------------------------------------------------
module key_matrix_midi_note_events_unit #(
  parameter int ROW_COUNT    = 8,
  parameter int COLUMN_COUNT = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // scan_column[3:0], row_levels[11:4], map_column[15:12], map_row[18:16],
  // map_note[25:19], zero fill above
  input  logic [31:0]                s_tdata,
  // req_type
  input  logic                       s_tuser,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // midi_status[7:0], midi_note[14:8], midi_velocity[21:15], event_row[24:22],
  // event_column[28:25], zero fill above
  output logic [31:0]                m_tdata,
  output logic                       m_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [kmne_pkg::CFG_W-1:0] cfg_data
);
  import kmne_pkg::*;

  kmne_cmd_t         cmd;
  kmne_status_t      status;
  logic [STAT_W-1:0] midi_status;
  logic [NOTE_W-1:0] midi_note;
  logic [VEL_W-1:0]  midi_velocity;
  logic [ROW_W-1:0]  event_row;
  logic [COL_W-1:0]  event_column;

  kmne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  kmne_datapath #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .scan_column   (s_tdata[3:0]),
    .row_levels    (s_tdata[11:4]),
    .map_column    (s_tdata[15:12]),
    .map_row       (s_tdata[18:16]),
    .map_note      (s_tdata[25:19]),
    .cmd           (cmd),
    .status        (status),
    .midi_status   (midi_status),
    .midi_note     (midi_note),
    .midi_velocity (midi_velocity),
    .event_row     (event_row),
    .event_column  (event_column),
    .last          (m_tlast)
  );

  assign m_tdata = {3'b000, event_column, event_row, midi_velocity, midi_note, midi_status};

endmodule

// ===== hw/rtl/kmne_checker.sv =====
// ---------------------------------------------------------------------------
// kmne_checker
// port-level checks of the key matrix midi note event block
// ---------------------------------------------------------------------------
`include "key_matrix_midi_note_events_unit_macros.svh"

module kmne_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);
  import kmne_pkg::*;

  // one item at a time: no new item while a message is offered
  `KMNE_ASSERT_SAME(a_no_take_while_sending, clk, rst, m_tvalid, !s_tready, "input taken during message")

  // a stalled message holds
  `KMNE_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled message changed")

  // status byte is always a note-on or note-off
  `KMNE_ASSERT_SAME(a_status_kind, clk, rst, m_tvalid, m_tdata[7:5] == 3'b100, "bad status byte")

  // a map write never causes a message
  `KMNE_ASSERT_NEXT(a_map_write_silent, clk, rst, s_tvalid && s_tready && s_tuser == REQ_MAP_WRITE, !m_tvalid, "message after map write")

  // after the final message the block takes input again
  `KMNE_ASSERT_NEXT(a_ready_after_last, clk, rst, m_tvalid && m_tready && m_tlast, s_tready, "not ready after last message")

endmodule

bind key_matrix_midi_note_events_unit kmne_checker u_checker (.*);

// ===== test/midi_event_checker.sv =====
// ---------------------------------------------------------------------------
// midi_event_checker
// watches the scan/map stream, the config port and the midi message stream;
// keeps its own pressed-key and note-map state and checks every message
// ---------------------------------------------------------------------------
module midi_event_checker #(
  parameter int ROW_COUNT    = 8,
  parameter int COLUMN_COUNT = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [31:0]                s_tdata,
  input  logic                       s_tuser,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [31:0]                m_tdata,
  input  logic                       m_tlast,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [kmne_pkg::CFG_W-1:0] cfg_data,
  output int                         outstanding,
  output int                         mismatches
);
  import kmne_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic              last;
  } midi_msg_t;

  logic [ROW_COUNT-1:0] key_down [COLUMN_COUNT];
  logic [NOTE_W-1:0]    note_of_key [1 << (COL_W + ROW_W)];
  logic [CHAN_W-1:0]    channel;
  logic [VEL_W-1:0]     velocity;
  midi_msg_t            pending_msgs [$];
  midi_msg_t            got, want;
  int                   reported;

  function automatic midi_msg_t make_msg(input logic [STAT_W-1:0] code,
                                         input logic [COL_W-1:0] col,
                                         input logic [ROW_W-1:0] row,
                                         input logic is_last);
    midi_msg_t msg;
    msg.status   = code | {{(STAT_W-CHAN_W){1'b0}}, channel};
    msg.note     = note_of_key[{col, row}];
    msg.velocity = velocity;
    msg.row      = row;
    msg.column   = col;
    msg.last     = is_last;
    return msg;
  endfunction

  // note-ons first, then note-offs, each in ascending row order
  task automatic predict_note_events(input logic [COL_W-1:0] col,
                                     input logic [7:0] levels);
    logic [ROW_COUNT-1:0] now, pressed, released;
    int total, k;
    if (col >= COLUMN_COUNT) return;
    now      = levels[ROW_COUNT-1:0];
    pressed  = now & ~key_down[col];
    released = ~now & key_down[col];
    total    = $countones(pressed) + $countones(released);
    k        = 0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      if (pressed[r]) begin
        pending_msgs.push_back(make_msg(NOTE_ON_CODE, col, r[ROW_W-1:0], k == total - 1));
        k++;
      end
    end
    for (int r = 0; r < ROW_COUNT; r++) begin
      if (released[r]) begin
        pending_msgs.push_back(make_msg(NOTE_OFF_CODE, col, r[ROW_W-1:0], k == total - 1));
        k++;
      end
    end
    key_down[col] = now;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_msgs.delete();
      for (int c = 0; c < COLUMN_COUNT; c++) key_down[c] = '0;
      channel  = '0;
      velocity = VELOCITY_RESET;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status   = m_tdata[7:0];
        got.note     = m_tdata[14:8];
        got.velocity = m_tdata[21:15];
        got.row      = m_tdata[24:22];
        got.column   = m_tdata[28:25];
        got.last     = m_tlast;
        if (pending_msgs.size() == 0) begin
          mismatches++;
          if (reported < 10) begin
            reported++;
            $display("unexpected message: status %h note %0d vel %0d row %0d col %0d last %b",
                     got.status, got.note, got.velocity, got.row, got.column, got.last);
          end
        end else begin
          want = pending_msgs.pop_front();
          if (got.status !== want.status || got.note !== want.note ||
              got.velocity !== want.velocity || got.row !== want.row ||
              got.column !== want.column || got.last !== want.last) begin
            mismatches++;
            if (reported < 10) begin
              reported++;
              $display("message mismatch: expected status %h note %0d vel %0d row %0d col %0d last %b",
                       want.status, want.note, want.velocity, want.row, want.column, want.last);
              $display("                  actual   status %h note %0d vel %0d row %0d col %0d last %b",
                       got.status, got.note, got.velocity, got.row, got.column, got.last);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MIDI_CHANNEL) channel = cfg_data[CHAN_W-1:0];
        else velocity = cfg_data[VEL_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == REQ_MAP_WRITE) begin
          if (s_tdata[15:12] < COLUMN_COUNT && s_tdata[18:16] < ROW_COUNT)
            note_of_key[{s_tdata[15:12], s_tdata[18:16]}] = s_tdata[25:19];
        end else begin
          predict_note_events(s_tdata[3:0], s_tdata[11:4]);
        end
      end
    end
    outstanding = pending_msgs.size();
  end

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// drives note-map writes and column scans into the key matrix unit, with
// random stalls on both streams and several channel/velocity settings
// ---------------------------------------------------------------------------
module testbench;
  import kmne_pkg::*;

  localparam int ROWS        = 8;
  localparam int COLUMNS     = 16;
  localparam int ITEMS_PHASE = 46;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic [31:0]        s_tdata   = '0;
  logic               s_tuser   = REQ_MAP_WRITE;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [31:0]        m_tdata;
  logic               m_tlast;
  logic               m_tvalid;
  logic               m_tready  = 1'b1;
  logic               cfg_we    = 1'b0;
  logic               cfg_index = CFG_MIDI_CHANNEL;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               quiet     = 1'b0;
  int                 outstanding;
  int                 mismatches;
  int                 cycle_count = 0;
  logic [ROWS-1:0]    mapped_rows [COLUMNS];
  logic [7:0]         last_levels [COLUMNS];
  logic [NOTE_W-1:0]  first_notes [ROWS] = '{7'd0, 7'd127, 7'd85, 7'd42,
                                             7'd1, 7'd126, 7'd64, 7'd63};

  key_matrix_midi_note_events_unit #(
    .ROW_COUNT   (ROWS),
    .COLUMN_COUNT(COLUMNS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  midi_event_checker #(
    .ROW_COUNT   (ROWS),
    .COLUMN_COUNT(COLUMNS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: stall bursts mixed with runs of steady ready
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        m_tready = 1'b1;
      end else if (hold == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          m_tready = 1'b0;
          hold = $urandom_range(1, 18);
        end else begin
          m_tready = 1'b1;
          hold = $urandom_range(1, 30);
        end
      end else begin
        hold--;
      end
    end
  end

  // called at a falling edge, returns at a falling edge after the transfer, at times after an idle gap
  task automatic send_item(input logic kind, input logic [31:0] payload);
    int gap;
    s_tuser  = kind;
    s_tdata  = payload;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // scan fields carry noise, the block must ignore them
  task automatic map_write(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                           input logic [NOTE_W-1:0] note);
    logic [7:0]       noise_levels;
    logic [COL_W-1:0] noise_col;
    noise_levels = 8'($urandom_range(0, 255));
    noise_col    = COL_W'($urandom_range(0, 15));
    mapped_rows[col][row] = 1'b1;
    send_item(REQ_MAP_WRITE, {6'd0, note, row, col, noise_levels, noise_col});
  endtask

  task automatic scan(input logic [COL_W-1:0] col, input logic [7:0] levels);
    logic [NOTE_W-1:0] noise_note;
    logic [ROW_W-1:0]  noise_row;
    logic [COL_W-1:0]  noise_col;
    noise_note = NOTE_W'($urandom_range(0, 127));
    noise_row  = ROW_W'($urandom_range(0, 7));
    noise_col  = COL_W'($urandom_range(0, 15));
    last_levels[col] = levels;
    send_item(REQ_SCAN, {6'd0, noise_note, noise_row, noise_col, levels, col});
  endtask

  // lets every message drain, then waits so that a resultless item can finish
  task automatic drain();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // only keys with a stored note may change state
  task automatic random_item();
    logic [COL_W-1:0] col;
    int               pick;
    col  = COL_W'($urandom_range(0, COLUMNS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 28)
      map_write(col, ROW_W'($urandom_range(0, ROWS - 1)), NOTE_W'($urandom_range(0, 127)));
    else if (pick < 38)
      scan(col, last_levels[col]);
    else
      scan(col, 8'($urandom_range(0, 255)) & mapped_rows[col]);
  endtask

  initial begin
    logic [CHAN_W-1:0] chan;
    logic [2:0]        chan_junk;
    for (int c = 0; c < COLUMNS; c++) begin
      mapped_rows[c] = '0;
      last_levels[c] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part under reset configuration
    for (int r = 0; r < ROWS; r++) begin
      map_write(4'd0, r[ROW_W-1:0], first_notes[r]);
      map_write(4'd15, r[ROW_W-1:0], 7'd127 - first_notes[r]);
    end
    scan(4'd0, 8'hff);    // every row pressed at once
    scan(4'd0, 8'hff);    // nothing changed
    scan(4'd0, 8'h00);    // every row released
    scan(4'd15, 8'h55);
    scan(4'd15, 8'haa);   // presses followed by releases
    scan(4'd7, 8'h00);    // column with no stored notes, no change
    scan(4'd15, 8'h80);
    scan(4'd15, 8'h00);   // single release

    for (int phase = 1; phase <= 4; phase++) begin
      drain();
      case (phase)
        1: begin
          write_reg(CFG_MIDI_CHANNEL, 7'd15);
          write_reg(CFG_NOTE_VELOCITY, 7'd127);
        end
        2: begin
          write_reg(CFG_MIDI_CHANNEL, 7'd0);
          write_reg(CFG_NOTE_VELOCITY, 7'd0);
        end
        default: begin
          // upper data bits are not part of the channel register
          chan      = CHAN_W'($urandom_range(0, 15));
          chan_junk = 3'($urandom_range(0, 7));
          write_reg(CFG_MIDI_CHANNEL, {chan_junk, chan});
          write_reg(CFG_NOTE_VELOCITY, CFG_W'($urandom_range(0, 127)));
        end
      endcase
      quiet = (phase == 4);
      for (int i = 0; i < ITEMS_PHASE; i++) random_item();
    end

    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
